/* rtl/wfdc_pkg.sv */
// Package for the wall-follow drive controller: item and config types,
// register indexes, mode codes and fixed thresholds. No dependencies.
`timescale 1ns / 1ps
package wfdc_pkg;

  // Default tick rate of the control loop.
  localparam int TICKS_PER_SECOND_DEF = 100;

  // Config register file.
  localparam int CFG_NUM   = 8;
  localparam int CFG_IDX_W = $clog2(CFG_NUM);
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STOP_DIST      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DIST      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_DIST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_TARGET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS_SIM        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_SPEED  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFE_TURN_RATE = 3'd7;

  // Drive modes.
  localparam logic [1:0] MODE_FOLLOW = 2'd0;
  localparam logic [1:0] MODE_BACK   = 2'd1;
  localparam logic [1:0] MODE_UTURN  = 2'd2;

  // Distances in mm.
  localparam logic [15:0] INVALID_MM = 16'd10000;
  localparam logic signed [17:0] TIGHT_MM      = 18'sd500;
  localparam logic signed [17:0] CORNER_MM     = 18'sd550;
  localparam logic signed [17:0] NEAR_FRONT_MM = 18'sd900;
  localparam logic signed [17:0] SIDE_GAP_MM   = 18'sd100;
  localparam logic signed [17:0] OPEN_LEFT_MM  = 18'sd250;
  localparam logic signed [17:0] OPEN_DIFF_MM  = 18'sd180;
  localparam logic signed [17:0] PAR_DIFF_MM   = 18'sd60;
  localparam logic signed [17:0] LEFT_SLACK_MM = 18'sd50;

  // Speed limits: |w| <= 1800, v <= floor((36000 - 13*|w|) / 144).
  localparam logic [10:0] W_MAX      = 11'd1800;
  localparam logic [7:0]  V_CAP_ZERO = 8'd250;
  localparam logic [15:0] LIM_NUM    = 16'd36000;
  localparam logic [17:0] LIM_RECIP  = 18'd233017;  // 2^25 / 144, rounded up
  localparam int          LIM_SHIFT  = 25;

  typedef struct packed {
    logic [15:0] dist_front;
    logic [15:0] dist_front_left;
    logic [15:0] dist_left_front;
    logic [15:0] dist_left_back;
    logic [15:0] dist_front_right;
    logic [4:0]  invalid_mask;
    logic        at_home;
  } in_item_t;

  typedef struct packed {
    logic signed [8:0]  linear_speed;
    logic signed [11:0] angular_speed;
    logic [1:0]         mode_now;
    logic               halted;
  } out_item_t;

  typedef struct packed {
    logic [15:0] stop_dist;
    logic [15:0] open_dist;
    logic [15:0] brake_dist;
    logic [15:0] wall_target;
    logic [9:0]  band;
    logic [9:0]  eps_sim;
    logic [7:0]  forward_speed;
    logic [10:0] turn_rate;   // clamped to W_MAX
    logic [7:0]  turn_v_cap;  // linear speed cap at turn_rate
  } cfg_t;

endpackage

/* rtl/wfdc_if.sv */
// Valid/ready channels of the wall-follow drive controller.
// Depends on wfdc_pkg for the item types.
`timescale 1ns / 1ps
interface wfdc_tick_if import wfdc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wfdc_cmd_if import wfdc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/wfdc_cfg.sv */
// Config register file and the values derived from it (clamped turn rate
// and the linear speed cap that goes with it). Depends on wfdc_pkg.
`timescale 1ns / 1ps
module wfdc_cfg import wfdc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [CFG_IDX_W-1:0] idx_i,
  input  logic [CFG_DAT_W-1:0] data_i,
  output cfg_t                 cfg_o
);

  logic [15:0] stop_dist_q, open_dist_q, brake_dist_q, wall_target_q;
  logic [9:0]  band_q, eps_sim_q;
  logic [7:0]  forward_speed_q;
  logic [10:0] turn_rate_q;

  logic [10:0] rate_c;
  logic [14:0] rate13;
  logic [15:0] lim_num;
  logic [33:0] lim_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_dist_q     <= 16'd450;
      open_dist_q     <= 16'd700;
      brake_dist_q    <= 16'd280;
      wall_target_q   <= 16'd400;
      band_q          <= 10'd30;
      eps_sim_q       <= 10'd40;
      forward_speed_q <= 8'd200;
      turn_rate_q     <= 11'd1200;
    end else if (we_i) begin
      unique case (idx_i)
        CFG_STOP_DIST:      stop_dist_q     <= data_i;
        CFG_OPEN_DIST:      open_dist_q     <= data_i;
        CFG_BRAKE_DIST:     brake_dist_q    <= data_i;
        CFG_WALL_TARGET:    wall_target_q   <= data_i;
        CFG_BAND:           band_q          <= data_i[9:0];
        CFG_EPS_SIM:        eps_sim_q       <= data_i[9:0];
        CFG_FORWARD_SPEED:  forward_speed_q <= data_i[7:0];
        CFG_SAFE_TURN_RATE: turn_rate_q     <= data_i[10:0];
        default: ;
      endcase
    end
  end

  // Clamp the turn rate, then cap = floor((36000 - 13*rate) / 144) by reciprocal.
  assign rate_c   = (turn_rate_q > W_MAX) ? W_MAX : turn_rate_q;
  assign rate13   = 15'(rate_c) * 15'd13;
  assign lim_num  = LIM_NUM - {1'b0, rate13};
  assign lim_prod = 34'(lim_num) * 34'(LIM_RECIP);

  always_comb begin
    cfg_o.stop_dist     = stop_dist_q;
    cfg_o.open_dist     = open_dist_q;
    cfg_o.brake_dist    = brake_dist_q;
    cfg_o.wall_target   = wall_target_q;
    cfg_o.band          = band_q;
    cfg_o.eps_sim       = eps_sim_q;
    cfg_o.forward_speed = forward_speed_q;
    cfg_o.turn_rate     = rate_c;
    cfg_o.turn_v_cap    = 8'(lim_prod >> LIM_SHIFT);
  end

endmodule

/* rtl/wfdc_core.sv */
// Per-tick decision logic and the drive state (mode, tick count, turn side,
// halt flag). Depends on wfdc_pkg.
`timescale 1ns / 1ps
module wfdc_core import wfdc_pkg::*; #(
  parameter int TicksPerSecond = TICKS_PER_SECOND_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,   // commit this item's state update
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output logic      emit_o,
  output out_item_t result_o
);

  localparam int TBackShort = (30 * TicksPerSecond + 50) / 100;
  localparam int TBackLong  = (35 * TicksPerSecond + 50) / 100;
  localparam int TUturn     = (120 * TicksPerSecond + 50) / 100;
  localparam int CntW       = $clog2(TUturn + 1);

  logic [1:0]      mode_q, mode_d;
  logic [CntW-1:0] ticks_q, ticks_d, ticks_dec;
  logic            turn_left_q, turn_left_d;
  logic            stopped_q, stopped_d;

  logic [15:0] d_f, d_fl, d_lf, d_lb, d_fr;
  logic signed [17:0] f, fl, lf, lb, fr, ls, band, eps, fstop, fgo, mb;
  logic signed [17:0] diff, adiff;
  logic signed [11:0] w_turn;
  logic signed [8:0]  v_turn, v_cruise;
  logic signed [8:0]  v;
  logic signed [11:0] w;
  logic               last;

  // Mask invalid ranges to the open-space reading.
  assign d_f  = item_i.invalid_mask[0] ? INVALID_MM : item_i.dist_front;
  assign d_fl = item_i.invalid_mask[1] ? INVALID_MM : item_i.dist_front_left;
  assign d_lf = item_i.invalid_mask[2] ? INVALID_MM : item_i.dist_left_front;
  assign d_lb = item_i.invalid_mask[3] ? INVALID_MM : item_i.dist_left_back;
  assign d_fr = item_i.invalid_mask[4] ? INVALID_MM : item_i.dist_front_right;

  assign f     = $signed({2'b00, d_f});
  assign fl    = $signed({2'b00, d_fl});
  assign lf    = $signed({2'b00, d_lf});
  assign lb    = $signed({2'b00, d_lb});
  assign fr    = $signed({2'b00, d_fr});
  assign ls    = $signed({2'b00, cfg_i.wall_target});
  assign fstop = $signed({2'b00, cfg_i.stop_dist});
  assign fgo   = $signed({2'b00, cfg_i.open_dist});
  assign mb    = $signed({2'b00, cfg_i.brake_dist});
  assign band  = $signed({8'd0, cfg_i.band});
  assign eps   = $signed({8'd0, cfg_i.eps_sim});
  assign diff  = lf - lb;
  assign adiff = (diff < 0) ? -diff : diff;

  // Turn-in-place rate is pre-clamped; v = 100 is capped at that rate.
  assign w_turn   = $signed({1'b0, cfg_i.turn_rate});
  assign v_turn   = (cfg_i.turn_v_cap < 8'd100) ? $signed({1'b0, cfg_i.turn_v_cap})
                                                 : 9'sd100;
  assign v_cruise = (cfg_i.forward_speed > V_CAP_ZERO) ? $signed({1'b0, V_CAP_ZERO})
                                                        : $signed({1'b0, cfg_i.forward_speed});

  assign ticks_dec = ticks_q - CntW'(1);
  assign last      = (ticks_dec == '0);

  always_comb begin
    mode_d      = mode_q;
    ticks_d     = ticks_q;
    turn_left_d = turn_left_q;
    stopped_d   = stopped_q;
    emit_o      = 1'b1;
    v           = 9'sd0;
    w           = 12'sd0;

    if (stopped_q) begin
      // Halted for good: zero speeds, nothing changes.
    end else if (item_i.at_home) begin
      stopped_d = 1'b1;
    end else if (mode_q != MODE_FOLLOW && ticks_q != '0) begin
      ticks_d = ticks_dec;
      if (mode_q == MODE_BACK) begin
        if (last) begin
          if (lf > ls + OPEN_LEFT_MM && diff > OPEN_DIFF_MM) begin
            turn_left_d = 1'b1;
          end
          mode_d  = MODE_UTURN;
          ticks_d = CntW'(TUturn);
        end
        v = -9'sd100;
      end else begin
        if ((f > fgo && adiff < PAR_DIFF_MM && lf > ls - LEFT_SLACK_MM) || last) begin
          mode_d  = MODE_FOLLOW;
          ticks_d = '0;
        end
        w = turn_left_q ? w_turn : -w_turn;
      end
    end else begin
      mode_d  = MODE_FOLLOW;
      ticks_d = '0;
      // Emergency brake and tight front only arm backing here.
      if (f < mb || fl < mb || fr < mb) begin
        turn_left_d = 1'b0;
        mode_d      = MODE_BACK;
        ticks_d     = CntW'(TBackShort);
      end
      if (f < fstop || (fl < TIGHT_MM && fr < TIGHT_MM)) begin
        turn_left_d = 1'b0;
        mode_d      = MODE_BACK;
        ticks_d     = CntW'(TBackLong);
      end

      if (f < fgo && f >= fstop && fl < fr - SIDE_GAP_MM) begin
        v = v_turn;
        w = -w_turn;
      end else if (f < fgo && f >= fstop && fr < fl - SIDE_GAP_MM) begin
        v = v_turn;
        w = w_turn;
      end else if (f >= fgo) begin
        if (adiff < eps) begin
          v = v_cruise;
        end else if (lf > ls + band) begin
          v = 9'sd120;
          w = 12'sd350;
        end else if (lf < ls - band) begin
          v = 9'sd120;
          w = -12'sd350;
        end else begin
          v = 9'sd160;
        end
      end else if (f < fstop) begin
        // Blocked ahead: arm short backing, no command this tick.
        turn_left_d = 1'b0;
        mode_d      = MODE_BACK;
        ticks_d     = CntW'(TBackShort);
        emit_o      = 1'b0;
      end else if (fl < CORNER_MM && fr < CORNER_MM) begin
        w = -w_turn;
      end else if (lb > ls + band) begin
        v = 9'sd100;
        w = 12'sd300;
      end else if (lb < ls - band) begin
        v = 9'sd100;
        w = -12'sd300;
      end else if (f < NEAR_FRONT_MM) begin
        v = 9'sd50;
        w = -12'sd600;
      end
    end

    result_o.linear_speed  = v;
    result_o.angular_speed = w;
    result_o.mode_now      = mode_d;
    result_o.halted        = stopped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FOLLOW;
      ticks_q     <= '0;
      turn_left_q <= 1'b0;
      stopped_q   <= 1'b0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      ticks_q     <= ticks_d;
      turn_left_q <= turn_left_d;
      stopped_q   <= stopped_d;
    end
  end

endmodule

/* rtl/wall_follow_drive_controller.sv */
// Wall-follow drive controller top level: tick input register, decision
// core, config registers and command output register.
// Depends on wfdc_pkg, wfdc_if, wfdc_cfg and wfdc_core.
// Usage:
//  - tick_i carries one sensor tick per item (five sector ranges in mm, an
//    invalid mask and the near-start flag); cmd_o carries the drive command
//    (linear and angular speed, mode after the tick, halted flag).
//  - The cfg_* port writes one config register per cycle with cfg_we_i high;
//    write only while no tick is in flight.
//  - An accepted item is held in the input register, decided by the core once
//    the output register is free, and its command is loaded into the output
//    register and shown on cmd_o. One item per cycle is sustained while cmd_o
//    does not stall, with a single decision pass between the two registers.
//  - A tick that arms backing with the front blocked produces no command;
//    every other tick produces exactly one.
//  - When cmd_o stalls, the command holds in the output register and one more
//    tick can wait in the input register; tick_i.ready drops after that.
//  - Reset clears both pipeline slots, the drive state (follow mode, not
//    halted) and loads the default config values.
//  - Near-start halts the controller for good: zero speeds, halted set.
`timescale 1ns / 1ps
module wall_follow_drive_controller import wfdc_pkg::*; #(
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  wfdc_tick_if.sink            tick_i,
  wfdc_cmd_if.source           cmd_o
);

  cfg_t      cfg;
  in_item_t  tick_q;
  logic      tick_valid_q;
  out_item_t cmd_q;
  logic      cmd_valid_q;

  logic      out_free;   // output register can take a new command
  logic      step;       // decide the held tick this cycle
  logic      emit;
  out_item_t result;

  assign out_free     = !cmd_valid_q || cmd_o.ready;
  assign step         = tick_valid_q && out_free;
  assign tick_i.ready = !tick_valid_q || out_free;

  wfdc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  wfdc_core #(
    .TicksPerSecond (TICKS_PER_SECOND)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (tick_q),
    .cfg_i    (cfg),
    .emit_o   (emit),
    .result_o (result)
  );

  // Input register: load on accept, drop once decided.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
    end else if (tick_i.valid && tick_i.ready) begin
      tick_valid_q <= 1'b1;
    end else if (step) begin
      tick_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      tick_q <= tick_i.data;
    end
  end

  // Output register: advance whenever free; hold while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (out_free) begin
      cmd_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      cmd_q <= result;
    end
  end

  assign cmd_o.valid = cmd_valid_q;
  assign cmd_o.data  = cmd_q;

endmodule

/* rtl/wfdc_checker.sv */
// Port-level checks for the wall-follow drive controller, bound to the top.
// Depends on wfdc_pkg and wall_follow_drive_controller.
`timescale 1ns / 1ps
module wfdc_checker import wfdc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic signed [8:0]  cmd_lin,
  input logic signed [11:0] cmd_ang,
  input logic [1:0]         cmd_mode,
  input logic               cmd_halted
);

  logic seen_halt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
    end else if (cmd_valid && cmd_ready && cmd_halted) begin
      seen_halt_q <= 1'b1;
    end
  end

  // Stalled command holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_lin) && $stable(cmd_ang)
      && $stable(cmd_mode) && $stable(cmd_halted))
    else $error("command changed while stalled");

  // Halt is permanent and commands zero speeds.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && seen_halt_q |-> cmd_halted && cmd_lin == 9'sd0 && cmd_ang == 12'sd0)
    else $error("command after halt is not a halt");

  a_halt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_halted |-> cmd_lin == 9'sd0 && cmd_ang == 12'sd0)
    else $error("halted command with nonzero speed");

  // Reverse motion only comes from backing: straight back, inside a maneuver.
  a_backing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_lin < 0
      |-> cmd_lin == -9'sd100 && cmd_ang == 12'sd0 && cmd_mode != MODE_FOLLOW)
    else $error("reverse command with wrong speeds or mode");

  // Speeds stay in the limits.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid |-> cmd_ang <= 12'sd1800 && cmd_ang >= -12'sd1800
      && cmd_lin <= 9'sd250 && cmd_lin >= -9'sd150)
    else $error("command speed out of range");

endmodule

bind wall_follow_drive_controller wfdc_checker u_wfdc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .cmd_valid  (cmd_o.valid),
  .cmd_ready  (cmd_o.ready),
  .cmd_lin    (cmd_o.data.linear_speed),
  .cmd_ang    (cmd_o.data.angular_speed),
  .cmd_mode   (cmd_o.data.mode_now),
  .cmd_halted (cmd_o.data.halted)
);
